// File: hw/rtl/rws_pkg.sv
package rws_pkg;

    localparam int POPULATION           = 2048;
    localparam int WEIGHT_FRACTION_BITS = 16;

    localparam int COST_W   = 16;
    localparam int RANDOM_W = 16;
    localparam int IDX_W    = $clog2(POPULATION);
    localparam int CNT_W    = $clog2(POPULATION + 1);
    localparam int WEIGHT_W = WEIGHT_FRACTION_BITS + 1;
    localparam int TOTAL_W  = $clog2(POPULATION) + WEIGHT_FRACTION_BITS + 1;
    localparam int PROD_W   = RANDOM_W + TOTAL_W;
    localparam int STEP_W   = $clog2(WEIGHT_W + 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_UNITY = WEIGHT_W'(1) << WEIGHT_FRACTION_BITS;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SELECT = 2'd2
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [COST_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [WEIGHT_W-1:0] quotient;
    } div_status_t;

endpackage

// File: hw/rtl/rws_divider.sv
module rws_divider
    import rws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  div_req_t    req,
    output div_status_t status
);

    logic [COST_W-1:0]   rem_reg, rem_next;
    logic [WEIGHT_W-1:0] quot_reg, quot_next;
    logic [COST_W-1:0]   divisor_reg, divisor_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [COST_W:0]     trial;
    logic                bit_in;
    logic                qbit;

    // Dividend is one followed by fraction-bit zeros; feed it MSB first.
    always_comb begin
        bit_in       = (step_reg == '0);
        trial        = {rem_reg, bit_in};
        qbit         = (trial >= {1'b0, divisor_reg});
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start) begin
            rem_next     = '0;
            quot_next    = '0;
            divisor_next = req.divisor;
            step_next    = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            rem_next  = qbit ? COST_W'(trial - {1'b0, divisor_reg}) : COST_W'(trial);
            quot_next = {quot_reg[WEIGHT_W-2:0], qbit};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(WEIGHT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
        step_reg    <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.quotient = quot_reg;

endmodule

// File: hw/rtl/rws_weight_ram.sv
module rws_weight_ram
    import rws_pkg::*;
(
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [WEIGHT_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [WEIGHT_W-1:0] rd_data
);

    logic [WEIGHT_W-1:0] weight_mem_reg [POPULATION];
    logic [WEIGHT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            weight_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= weight_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/roulette_wheel_selector_core.sv
// Roulette wheel selector: cost-weighted random pick over a stored population.
// Input channel s_*: s_tuser carries the command (clear, load, select), s_tdata
// carries the cost for a load and the 16-bit random fraction for a select.
// Clear empties the population. Load computes weight = 2^16 / cost with a
// bit-serial divider and writes it to the weight memory; a zero cost skips
// the divider. Loads past the population size are dropped. Clear and load
// give no item out.
// Select forms the target from fraction * weight sum, then scans the weight
// memory one entry per cycle (one read port, registered read), keeping a
// running sum until it reaches the target or the last entry has been added.
// No new item is taken until the result has moved to the output register.
// A select on an empty population returns index 0 with empty_error set.
// Results leave through an output register on m_*; the block accepts the next
// item while a result waits there, and holds a new select result until the
// receiver takes the old one. Reset (aresetn low, synchronous) empties the
// population and drops any pending result; memory contents are not cleared.
module roulette_wheel_selector_core
    import rws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] cost, [31:16] random_fraction
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] chosen_index, rest zero
    output logic [1:0]  m_tuser    // [0] empty_error, [1] zero_cost_seen
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                zero_reg, zero_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TOTAL_W-1:0]  running_reg, running_next;
    logic [CNT_W-1:0]    rd_addr_reg, rd_addr_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic                res_err_reg, res_err_next;
    logic                m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic                m_err_reg, m_err_next;
    logic                m_zero_reg, m_zero_next;

    logic                accept;
    cmd_t                cmd;
    logic [COST_W-1:0]   in_cost;
    logic [RANDOM_W-1:0] in_frac;
    div_req_t            div_req;
    div_status_t         div_status;
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [WEIGHT_W-1:0] ram_rd_data;
    logic [TOTAL_W-1:0]  target;
    logic [TOTAL_W-1:0]  scan_sum;
    logic                last_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign in_cost  = s_tdata[COST_W-1:0];
    assign in_frac  = s_tdata[COST_W +: RANDOM_W];

    assign target     = prod_reg[RANDOM_W +: TOTAL_W];
    assign scan_sum   = running_reg + TOTAL_W'(ram_rd_data);
    assign last_entry = (CNT_W'(pend_idx_reg) + CNT_W'(1) == count_reg);

    rws_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .status  (div_status)
    );

    rws_weight_ram u_weight_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (weight_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_addr_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        zero_next      = zero_reg;
        weight_next    = weight_reg;
        prod_next      = prod_reg;
        running_next   = running_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        res_idx_next   = res_idx_reg;
        res_err_next   = res_err_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_idx_next     = m_idx_reg;
        m_err_next     = m_err_reg;
        m_zero_next    = m_zero_reg;
        div_req.start   = 1'b0;
        div_req.divisor = in_cost;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_CLEAR: begin
                            count_next = '0;
                            total_next = '0;
                            zero_next  = 1'b0;
                        end
                        CMD_LOAD: begin
                            if (count_reg < CNT_W'(POPULATION)) begin
                                if (in_cost == '0) begin
                                    weight_next = WEIGHT_UNITY;
                                    zero_next   = 1'b1;
                                    state_next  = ST_LOAD;
                                end else begin
                                    div_req.start = 1'b1;
                                    state_next    = ST_DIV;
                                end
                            end
                        end
                        CMD_SELECT: begin
                            prod_next    = PROD_W'(in_frac) * PROD_W'(total_reg);
                            running_next = '0;
                            rd_addr_next = '0;
                            if (count_reg == '0) begin
                                res_idx_next = '0;
                                res_err_next = 1'b1;
                                state_next   = ST_OUT;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    weight_next = div_status.quotient;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ram_wr_en  = 1'b1;
                total_next = total_reg + TOTAL_W'(weight_reg);
                count_next = count_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                // Issue the next read while the previous word comes back.
                if (rd_addr_reg < count_reg) begin
                    ram_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr_reg[IDX_W-1:0];
                    rd_addr_next  = rd_addr_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    running_next = scan_sum;
                    if (scan_sum >= target || last_entry) begin
                        res_idx_next = pend_idx_reg;
                        res_err_next = 1'b0;
                        pend_next    = 1'b0;
                        state_next   = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    m_err_next   = res_err_reg;
                    m_zero_next  = zero_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        weight_reg   <= weight_next;
        prod_reg     <= prod_next;
        running_reg  <= running_next;
        rd_addr_reg  <= rd_addr_next;
        pend_idx_reg <= pend_idx_next;
        res_idx_reg  <= res_idx_next;
        res_err_reg  <= res_err_next;
        m_idx_reg    <= m_idx_next;
        m_err_reg    <= m_err_next;
        m_zero_reg   <= m_zero_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            zero_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            zero_reg    <= zero_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 16'(m_idx_reg);
    assign m_tuser  = {m_zero_reg, m_err_reg};

endmodule
